### rtl/two_level_page_walk_core_macros.svh
// Assertion macros used by the page walk core RTL.
// Depends on a clk_i clock and an rst_ni active-low reset in the using module.
`ifndef TWO_LEVEL_PAGE_WALK_CORE_MACROS_SVH
`define TWO_LEVEL_PAGE_WALK_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLPW_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLPW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/tlpw_pkg.sv
// Package for the two-level page walk core: sizes, codes and types.
// Used by the generic RAM and the top level; depends on nothing.
`timescale 1ns / 1ps

package tlpw_pkg;

  // Geometry of physical memory and of table entries.
  localparam int unsigned PageCountDefault = 128;
  localparam int unsigned PageBytes        = 32;
  localparam int unsigned OffW             = $clog2(PageBytes);
  localparam int unsigned EntryW           = 8;
  localparam int unsigned EntryPageW       = 7;
  localparam int unsigned EntryValidBit    = 7;
  localparam int unsigned MemDepthDefault  = PageCountDefault * PageBytes;

  // Directory page after reset.
  localparam logic [EntryPageW-1:0] DirPageReset = 7'h11;

  // Register map.
  localparam int unsigned PaddrW     = 2;
  localparam logic [PaddrW-1:0] RegDirPage = 2'd0;

  // Item commands.
  localparam logic CmdLoad      = 1'b0;
  localparam logic CmdTranslate = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusDirFault = 2'd1,
    StatusTabFault = 2'd2
  } status_e;

  // Walk sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StDir,
    StTab,
    StData
  } state_e;

endpackage

### rtl/tlpw_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on tlpw_pkg for its default sizes.
`timescale 1ns / 1ps

module tlpw_ram
  import tlpw_pkg::*;
#(
  parameter int unsigned Width = EntryW,
  parameter int unsigned Depth = MemDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write when enabled, read the addressed entry every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/two_level_page_walk_core.sv
// Two-level page walk core: a load item writes one byte and a translate item walks the tables.
// A walk issues one dependent read of the single-port byte memory per state (directory,
// table, data) and then registers the result; a fault ends it early after the failing read.
// The result strobe done_o rises the cycle after the last read; busy drops with it,
// so the next item may start in that same cycle. The receiver cannot stall.
// Reset clears the sequencer and sets directory_page to 17; memory is not cleared.
`timescale 1ns / 1ps

`include "two_level_page_walk_core_macros.svh"

module two_level_page_walk_core
  import tlpw_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = PageCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item command port
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [14:0] virtual_address_i,
  input  logic [11:0] load_address_i,
  input  logic [7:0]  load_byte_i,
  // Result port
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] physical_address_o,
  output logic [7:0]  data_value_o,
  output logic [7:0]  directory_entry_o,
  output logic [7:0]  table_entry_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned MemBytes = PAGE_COUNT * PageBytes;
  localparam int unsigned AddrW    = $clog2(MemBytes);
  localparam int unsigned PageW    = $clog2(PAGE_COUNT);
  localparam int unsigned TabPages = 1 << EntryPageW;

  state_e                state_q, state_d;
  logic [EntryPageW-1:0] dir_page_q;
  logic [OffW-1:0]       tab_idx_q, tab_idx_d;
  logic [OffW-1:0]       off_q, off_d;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [11:0]           pa_q, pa_d;
  logic [EntryW-1:0]     data_q, data_d;
  logic [EntryW-1:0]     pde_q, pde_d;
  logic [EntryW-1:0]     pte_q, pte_d;

  logic                  mem_we;
  logic [AddrW-1:0]      mem_addr;
  logic [EntryW-1:0]     mem_rdata;
  logic                  accept;
  logic                  load_in_range;
  logic [PageW-1:0]      page_map [TabPages];
  logic [PageW-1:0]      dir_page_red;
  logic [PageW-1:0]      entry_page_red;

  // Page numbers reduced modulo the page count, as a constant table.
  for (genvar g = 0; g < TabPages; g++) begin : g_page_map
    localparam int unsigned Reduced = g % PAGE_COUNT;
    assign page_map[g] = PageW'(Reduced);
  end

  assign dir_page_red   = page_map[dir_page_q];
  assign entry_page_red = page_map[mem_rdata[EntryPageW-1:0]];

  // Configuration register, written in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == RegDirPage) ? 32'(dir_page_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_page_q <= DirPageReset;
    end else if (psel && penable && pwrite && pready && (paddr == RegDirPage)) begin
      dir_page_q <= pwdata[EntryPageW-1:0];
    end
  end

  // Byte memory holding all pages, including the tables.
  tlpw_ram #(
    .Width (EntryW),
    .Depth (MemBytes)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (load_byte_i),
    .rdata_o (mem_rdata)
  );

  assign busy          = (state_q != StIdle);
  assign accept        = start && !busy;
  assign load_in_range = ({1'b0, load_address_i} < 13'(MemBytes));

  // Walk sequencer: one memory read per state, the result built in registers.
  always_comb begin
    state_d   = state_q;
    tab_idx_d = tab_idx_q;
    off_d     = off_q;
    done_d    = 1'b0;
    status_d  = status_q;
    pa_d      = pa_q;
    data_d    = data_q;
    pde_d     = pde_q;
    pte_d     = pte_q;
    mem_we    = 1'b0;
    mem_addr  = {dir_page_red, virtual_address_i[14:10]};

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          status_d = StatusOk;
          pa_d     = '0;
          data_d   = '0;
          pde_d    = '0;
          pte_d    = '0;
          if (cmd_i == CmdLoad) begin
            // Load: write the byte now and acknowledge next cycle.
            mem_we   = load_in_range;
            mem_addr = load_address_i[AddrW-1:0];
            done_d   = 1'b1;
          end else begin
            // Translate: the directory read is issued on acceptance.
            tab_idx_d = virtual_address_i[9:5];
            off_d     = virtual_address_i[4:0];
            state_d   = StDir;
          end
        end
      end
      StDir: begin
        pde_d    = mem_rdata;
        mem_addr = {entry_page_red, tab_idx_q};
        if (!mem_rdata[EntryValidBit]) begin
          status_d = StatusDirFault;
          done_d   = 1'b1;
          state_d  = StIdle;
        end else begin
          state_d = StTab;
        end
      end
      StTab: begin
        pte_d    = mem_rdata;
        mem_addr = {entry_page_red, off_q};
        if (!mem_rdata[EntryValidBit]) begin
          status_d = StatusTabFault;
          done_d   = 1'b1;
          state_d  = StIdle;
        end else begin
          pa_d    = 12'({entry_page_red, off_q});
          state_d = StData;
        end
      end
      StData: begin
        data_d  = mem_rdata;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Walk fields and result registers.
  always_ff @(posedge clk_i) begin
    tab_idx_q <= tab_idx_d;
    off_q     <= off_d;
    status_q  <= status_d;
    pa_q      <= pa_d;
    data_q    <= data_d;
    pde_q     <= pde_d;
    pte_q     <= pte_d;
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign physical_address_o = pa_q;
  assign data_value_o       = data_q;
  assign directory_entry_o  = pde_q;
  assign table_entry_o      = pte_q;

  // Checks on the sequencer and on the shape of results.
  `TLPW_ASSERT_NOW(a_done_when_idle, done_o, state_q == StIdle,
    "result shown while a walk is still running")
  `TLPW_ASSERT_NEXT(a_load_acked, accept && (cmd_i == CmdLoad), done_o && (status_o == StatusOk),
    "load item not acknowledged in the next cycle")
  `TLPW_ASSERT_NOW(a_fault_zero, done_o && (status_o != StatusOk),
    (physical_address_o == 12'd0) && (data_value_o == 8'd0),
    "faulting walk reports a nonzero address or data")
  `TLPW_ASSERT_NOW(a_dir_fault, done_o && (status_o == StatusDirFault),
    !directory_entry_o[EntryValidBit] && (table_entry_o == 8'd0),
    "directory fault with a valid entry or a table entry")
  `TLPW_ASSERT_NEXT(a_walk_order, state_q == StTab, (state_q == StIdle) || (state_q == StData),
    "table read not followed by data read or completion")

endmodule

### test/two_level_page_walk_core_tb.sv
// Self-checking testbench for two_level_page_walk_core: loads and translate walks over the
// command port, directory page changes over APB, and an in-order scoreboard of results.
// Depends on tlpw_pkg and the two_level_page_walk_core RTL.
`timescale 1ns / 1ps

module two_level_page_walk_core_tb;
  import tlpw_pkg::*;

  localparam int PageCount     = PageCountDefault;
  localparam int MemBytes      = MemDepthDefault;
  localparam int WatchdogLimit = 5000;
  localparam int ItemsPerPhase = 340;

  // One result item as the block reports it.
  typedef struct {
    status_e     status;
    logic [11:0] phys_addr;
    logic [7:0]  data_value;
    logic [7:0]  dir_entry;
    logic [7:0]  tab_entry;
  } walk_result_t;

  // Keeps a byte image of physical memory and the directory page, predicts each
  // item's result when it is accepted, and matches results against them in order.
  class walk_scoreboard;
    logic [6:0]   dir_page;
    bit [7:0]     mem_img [MemBytes];
    walk_result_t pending_walks [$];
    int           errors;

    function new();
      dir_page = DirPageReset;
      errors   = 0;
    endfunction

    function bit [7:0] read_byte(int page, int off);
      int a;
      a = (page % PageCount) * PageBytes + off;
      return (a < MemBytes) ? mem_img[a] : 8'h00;
    endfunction

    function walk_result_t predict_walk(logic c, logic [14:0] va, logic [11:0] la,
                                        logic [7:0] lb);
      walk_result_t r;
      logic [7:0]   pde;
      logic [7:0]   pte;
      int           pfn;
      r.status     = StatusOk;
      r.phys_addr  = '0;
      r.data_value = '0;
      r.dir_entry  = '0;
      r.tab_entry  = '0;
      if (c == CmdLoad) begin
        // Loads beyond the end of memory are acknowledged but dropped.
        if (la < MemBytes) mem_img[la] = lb;
        return r;
      end
      pde = read_byte(dir_page, va[14:10]);
      r.dir_entry = pde;
      if (!pde[EntryValidBit]) begin
        r.status = StatusDirFault;
        return r;
      end
      pte = read_byte(pde[EntryPageW-1:0], va[9:5]);
      r.tab_entry = pte;
      if (!pte[EntryValidBit]) begin
        r.status = StatusTabFault;
        return r;
      end
      pfn = pte[EntryPageW-1:0] % PageCount;
      r.phys_addr  = 12'(pfn * PageBytes + va[4:0]);
      r.data_value = read_byte(pfn, va[4:0]);
      return r;
    endfunction

    function void note_item(logic c, logic [14:0] va, logic [11:0] la, logic [7:0] lb);
      walk_result_t expected;
      expected = predict_walk(c, va, la, lb);
      pending_walks.insert(pending_walks.size(), expected);
    endfunction

    function void report(string field, logic [11:0] want, logic [11:0] seen);
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
    endfunction

    function void check_result(logic [1:0] st, logic [11:0] pa, logic [7:0] dv,
                               logic [7:0] de, logic [7:0] te);
      walk_result_t want;
      if (pending_walks.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, expected none, actual status %0d",
                 $time, st);
        return;
      end
      want = pending_walks.pop_front();
      if (st !== want.status)     report("status", 12'(want.status), 12'(st));
      if (pa !== want.phys_addr)  report("physical_address", want.phys_addr, pa);
      if (dv !== want.data_value) report("data_value", 12'(want.data_value), 12'(dv));
      if (de !== want.dir_entry)  report("directory_entry", 12'(want.dir_entry), 12'(de));
      if (te !== want.tab_entry)  report("table_entry", 12'(want.tab_entry), 12'(te));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              cmd_i;
  logic [14:0]       virtual_address_i;
  logic [11:0]       load_address_i;
  logic [7:0]        load_byte_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [11:0]       physical_address_o;
  logic [7:0]        data_value_o;
  logic [7:0]        directory_entry_o;
  logic [7:0]        table_entry_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  walk_scoreboard sb = new();

  // Bytes written so far; memory is not cleared by reset, so walks may only touch these.
  bit          loaded [MemBytes];
  logic [14:0] used_vas [$];
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  two_level_page_walk_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .virtual_address_i  (virtual_address_i),
    .load_address_i     (load_address_i),
    .load_byte_i        (load_byte_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .physical_address_o (physical_address_o),
    .data_value_o       (data_value_o),
    .directory_entry_o  (directory_entry_o),
    .table_entry_o      (table_entry_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(status_o, physical_address_o, data_value_o, directory_entry_o,
                      table_entry_o);
  end

  // Watchdog: ends the run when neither side makes progress for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no item accepted for %0d cycles", $time, WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap before the next item: mostly short, a few long, and some back-to-back bursts.
  function automatic int draw_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int page_base(int pg);
    return (pg % PageCount) * PageBytes;
  endfunction

  // True when every byte the walk for va would read has been loaded.
  function automatic bit walk_reads_loaded(logic [14:0] va);
    int         a;
    logic [7:0] pde;
    logic [7:0] pte;
    a = page_base(sb.dir_page) + va[14:10];
    if (!loaded[a]) return 1'b0;
    pde = sb.mem_img[a];
    if (!pde[EntryValidBit]) return 1'b1;
    a = page_base(pde[EntryPageW-1:0]) + va[9:5];
    if (!loaded[a]) return 1'b0;
    pte = sb.mem_img[a];
    if (!pte[EntryValidBit]) return 1'b1;
    a = page_base(pte[EntryPageW-1:0]) + va[4:0];
    return loaded[a];
  endfunction

  // Presents one item, holds it until accepted, then idles for a random gap.
  task automatic send_item(logic c, logic [14:0] va, logic [11:0] la, logic [7:0] lb);
    int gap;
    start             <= 1'b1;
    cmd_i             <= c;
    virtual_address_i <= va;
    load_address_i    <= la;
    load_byte_i       <= lb;
    do @(posedge clk_i); while (busy);
    sb.note_item(c, va, la, lb);
    if (c == CmdLoad && la < MemBytes) loaded[la] = 1'b1;
    items_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_byte(int addr, logic [7:0] value);
    send_item(CmdLoad, 15'($urandom()), 12'(addr), value);
  endtask

  task automatic translate(logic [14:0] va);
    send_item(CmdTranslate, va, 12'($urandom()), 8'($urandom()));
    used_vas.insert(used_vas.size(), va);
    if (used_vas.size() > 64) void'(used_vas.pop_front());
  endtask

  // Sets up the entries for one walk and translates it, ending in the given status.
  task automatic walk(logic [4:0] di, logic [4:0] ti, logic [4:0] off, logic [6:0] tp,
                      logic [6:0] dp, status_e kind, logic [6:0] junk, logic [7:0] dbyte);
    logic [14:0] va;
    va = {di, ti, off};
    if (kind == StatusDirFault) begin
      load_byte(page_base(sb.dir_page) + di, {1'b0, junk});
    end else begin
      load_byte(page_base(sb.dir_page) + di, {1'b1, tp});
      if (kind == StatusTabFault) begin
        load_byte(page_base(tp) + ti, {1'b0, junk});
      end else begin
        load_byte(page_base(tp) + ti, {1'b1, dp});
        load_byte(page_base(dp) + off, dbyte);
      end
    end
    // A table entry may land on the directory entry itself; skip walks that would
    // then reach a byte never written.
    if (walk_reads_loaded(va)) translate(va);
  endtask

  task automatic noise_load();
    if ($urandom_range(0, 1))
      load_byte($urandom_range(0, 4095), 8'($urandom()));
    else
      load_byte(page_base(sb.dir_page) + $urandom_range(0, 31), 8'($urandom()));
  endtask

  // Register write over APB: setup cycle, then access until pready.
  task automatic write_dir_page(logic [6:0] pg);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegDirPage;
    pwdata  <= ($urandom() & ~32'h7f) | 32'(pg);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.dir_page = pg;
  endtask

  // Stops sending, waits for every outstanding result, then idles before returning.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_walks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_step();
    int      r;
    int      k;
    status_e kind;
    logic [14:0] va;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      k = $urandom_range(0, 99);
      kind = (k < 70) ? StatusOk : (k < 85) ? StatusDirFault : StatusTabFault;
      walk(5'($urandom()), 5'($urandom()), 5'($urandom()), 7'($urandom()),
           7'($urandom()), kind, 7'($urandom()), 8'($urandom()));
    end else if (r < 78) begin
      // Revisit an earlier address, or try a fresh one, when all its bytes exist.
      if (r < 70 && used_vas.size() > 0)
        va = used_vas[$urandom_range(0, used_vas.size() - 1)];
      else
        va = 15'($urandom());
      if (walk_reads_loaded(va)) translate(va);
      else noise_load();
    end else begin
      noise_load();
    end
  endtask

  // Main stimulus.
  initial begin
    logic [6:0] phase_pages [5];
    int         target;
    rst_ni            <= 1'b0;
    start             <= 1'b0;
    cmd_i             <= CmdLoad;
    virtual_address_i <= '0;
    load_address_i    <= '0;
    load_byte_i       <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset directory page.
    load_byte(0, 8'hff);
    load_byte(MemBytes - 1, 8'h00);
    walk(5'd0, 5'd31, 5'd31, 7'd127, 7'd0, StatusOk, 7'd0, 8'hff);
    walk(5'd31, 5'd0, 5'd0, 7'd0, 7'd127, StatusOk, 7'd0, 8'h00);
    walk(5'd30, 5'd31, 5'd31, 7'd0, 7'd0, StatusDirFault, 7'h7f, 8'h00);
    walk(5'd1, 5'd0, 5'd0, 7'd5, 7'd0, StatusTabFault, 7'h00, 8'h00);
    if (walk_reads_loaded(15'h7fff)) translate(15'h7fff);
    settle();

    // Random phases, each under its own directory page.
    phase_pages[0] = 7'd0;
    phase_pages[1] = 7'd127;
    phase_pages[2] = 7'($urandom());
    phase_pages[3] = 7'($urandom());
    phase_pages[4] = DirPageReset;
    foreach (phase_pages[p]) begin
      write_dir_page(phase_pages[p]);
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) random_step();
      settle();
    end

    if (sb.pending_walks.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending_walks.size());
    if (sb.errors == 0 && sb.pending_walks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tlpw_pkg.sv
rtl/tlpw_ram.sv
rtl/two_level_page_walk_core.sv
test/two_level_page_walk_core_tb.sv
